// ----- design/dimer_height_site_update_core_macros.svh -----
`ifndef DIMER_HEIGHT_SITE_UPDATE_CORE_MACROS_SVH
`define DIMER_HEIGHT_SITE_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define DHSU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DHSU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dhsu_pkg.sv -----
package dhsu_pkg;

  localparam int DHSU_ROWS   = 4;
  localparam int DHSU_COLS   = 4;
  localparam int DHSU_LAYERS = 40;

  localparam int NUM_SLOTS = 20;
  localparam int SLOT_W    = 5;
  localparam logic [SLOT_W-1:0] SLOT_LAST = 5'd19;

  typedef logic [1:0] height_t;

  localparam logic [1:0] ACT_FLIP  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic CFG_ENERGY_STEP = 1'b0;
  localparam logic CFG_LINK_WEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OUT_DONE      = 3'd0,
    OUT_WRONG_SUB = 3'd1,
    OUT_NOT_FLIP  = 3'd2,
    OUT_REJECT    = 3'd3,
    OUT_FLIPPED   = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  layer_index;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [15:0] neg_log_uniform;
    logic [1:0]  write_height;
  } item_t;

  typedef struct packed {
    logic signed [2:0] dz;
    logic signed [2:0] dx;
    logic signed [2:0] dy;
  } offset_t;

  typedef struct packed {
    logic     load;
    logic     reduce;
    logic     read_issue;
    logic     step_inc;
    logic     clear_wr;
    logic     wr_site;
    logic     wr_link;
    logic     wr_item;
    logic     eval;
    logic     mult;
    logic     set_outcome;
    outcome_t outcome;
    logic     out_load;
  } dhsu_cmd_t;

  typedef struct packed {
    logic reduce_done;
    logic read_last;
    logic clear_last;
    logic is_attempt;
    logic is_write;
    logic parity_ok;
    logic flippable;
    logic accept;
    logic out_free;
  } dhsu_status_t;

  // site, ring of four, distance-two ring, diagonals, upper layer site and ring, time links
  function automatic offset_t slot_offset(input logic [SLOT_W-1:0] s);
    offset_t o;
    o = '0;
    unique case (s)
      5'd0:  o = '{3'sd0,  3'sd0,  3'sd0};
      5'd1:  o = '{3'sd0,  3'sd1,  3'sd0};
      5'd2:  o = '{3'sd0, -3'sd1,  3'sd0};
      5'd3:  o = '{3'sd0,  3'sd0,  3'sd1};
      5'd4:  o = '{3'sd0,  3'sd0, -3'sd1};
      5'd5:  o = '{3'sd0,  3'sd2,  3'sd0};
      5'd6:  o = '{3'sd0, -3'sd2,  3'sd0};
      5'd7:  o = '{3'sd0,  3'sd0,  3'sd2};
      5'd8:  o = '{3'sd0,  3'sd0, -3'sd2};
      5'd9:  o = '{3'sd0,  3'sd1,  3'sd1};
      5'd10: o = '{3'sd0,  3'sd1, -3'sd1};
      5'd11: o = '{3'sd0, -3'sd1,  3'sd1};
      5'd12: o = '{3'sd0, -3'sd1, -3'sd1};
      5'd13: o = '{3'sd1,  3'sd0,  3'sd0};
      5'd14: o = '{3'sd1,  3'sd1,  3'sd0};
      5'd15: o = '{3'sd1, -3'sd1,  3'sd0};
      5'd16: o = '{3'sd1,  3'sd0,  3'sd1};
      5'd17: o = '{3'sd1,  3'sd0, -3'sd1};
      5'd18: o = '{-3'sd1, 3'sd0,  3'sd0};
      5'd19: o = '{3'sd2,  3'sd0,  3'sd0};
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic logic plaq_ok(input height_t hc, input height_t hxm, input height_t hxp,
                                   input height_t hyp, input height_t hym, input logic par);
    height_t want;
    want = par ? 2'd1 : 2'd3;
    return (((hc - hxm) == 2'd1) && ((hxp - hc) == 2'd1)) ||
           (((hyp - hc) == want) && ((hym - hc) == want));
  endfunction

endpackage

// ----- design/dhsu_item_if.sv -----
interface dhsu_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  layer_index;
  logic [1:0]  row;
  logic [1:0]  col;
  logic [15:0] neg_log_uniform;
  logic [1:0]  write_height;

  modport source (output valid, action, layer_index, row, col, neg_log_uniform, write_height,
                  input ready);
  modport sink (input valid, action, layer_index, row, col, neg_log_uniform, write_height,
                output ready);
endinterface

// ----- design/dhsu_result_if.sv -----
interface dhsu_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  logic [1:0] read_height;

  modport source (output valid, outcome, read_height, input ready);
  modport sink (input valid, outcome, read_height, output ready);
endinterface

// ----- design/dhsu_ram.sv -----
module dhsu_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/dhsu_datapath.sv -----
module dhsu_datapath #(
  parameter int ROWS   = dhsu_pkg::DHSU_ROWS,
  parameter int COLS   = dhsu_pkg::DHSU_COLS,
  parameter int LAYERS = dhsu_pkg::DHSU_LAYERS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dhsu_pkg::item_t         item_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [15:0]             cfg_data,
  input  dhsu_pkg::dhsu_cmd_t     cmd,
  output dhsu_pkg::dhsu_status_t  sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [2:0]              out_outcome,
  output logic [1:0]              out_height
);
  import dhsu_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int LW    = $clog2(LAYERS);
  localparam int DEPTH = LAYERS * ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XIW   = (RW > 2) ? RW : 2;
  localparam int YIW   = (CW > 2) ? CW : 2;
  localparam int ZIW   = (LW > 6) ? LW : 6;
  localparam logic [XIW:0] XLIM = (XIW+1)'(ROWS);
  localparam logic [YIW:0] YLIM = (YIW+1)'(COLS);
  localparam logic [ZIW:0] ZLIM = (ZIW+1)'(LAYERS);

  logic signed [15:0] energy_step;
  logic [15:0]        link_weight;

  logic [1:0]     act;
  logic [ZIW-1:0] zi;
  logic [XIW-1:0] xi;
  logic [YIW-1:0] yi;
  logic [15:0]    nlu;
  height_t        wh;

  logic [LW-1:0] z;
  logic [RW-1:0] x;
  logic [CW-1:0] y;

  logic [SLOT_W-1:0] step;

  offset_t off;
  logic signed [LW+2:0] sz;
  logic signed [RW+2:0] sx;
  logic signed [CW+2:0] sy;
  logic [LW-1:0] tz;
  logic [RW-1:0] tx;
  logic [CW-1:0] ty;
  logic [AW-1:0] gen_addr;

  logic [AW-1:0] caddr;
  logic [RW-1:0] cx;
  logic [CW-1:0] cy;
  height_t       cval;
  logic [1:0]    crow;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  height_t       mem_wdata;
  height_t       mem_rdata;

  logic              rd_pend;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_par;
  logic              rd_site;

  height_t hs [NUM_SLOTS];
  logic    ps [NUM_SLOTS];
  logic    ss [NUM_SLOTS];
  height_t va [13];

  logic bs, ba, bb, bc, bd, aa, ab, ac, ad, match, c1, c2;
  logic [2:0] kb, ka;

  logic signed [3:0]  k_reg;
  logic signed [2:0]  c_reg;
  logic               parity_reg;
  logic               flip_reg;
  logic signed [19:0] p1;
  logic signed [19:0] p2;
  logic signed [20:0] bound;
  outcome_t           outcome_q;

  assign z = zi[LW-1:0];
  assign x = xi[RW-1:0];
  assign y = yi[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_step <= 16'sd46;
      link_weight <= 16'd3069;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENERGY_STEP: energy_step <= $signed(cfg_data);
        CFG_LINK_WEIGHT: link_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= item_data.action;
      zi  <= ZIW'(item_data.layer_index);
      xi  <= XIW'(item_data.row);
      yi  <= YIW'(item_data.col);
      nlu <= item_data.neg_log_uniform;
      wh  <= item_data.write_height;
    end else if (cmd.reduce) begin
      if ({1'b0, zi} >= ZLIM) zi <= zi - ZLIM[ZIW-1:0];
      if ({1'b0, xi} >= XLIM) xi <= xi - XLIM[XIW-1:0];
      if ({1'b0, yi} >= YLIM) yi <= yi - YLIM[YIW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + 1'b1;
    end
  end

  always_comb begin
    off = '0;
    if (cmd.read_issue) begin
      off = slot_offset(step);
    end else if (cmd.wr_link) begin
      off = '{3'sd1, 3'sd0, 3'sd0};
    end
    sz = $signed({3'b000, z}) + (LW+3)'(off.dz);
    if (sz < 0) sz = sz + (LW+3)'(LAYERS);
    else if (sz >= LAYERS) sz = sz - (LW+3)'(LAYERS);
    sx = $signed({3'b000, x}) + (RW+3)'(off.dx);
    if (sx < 0) sx = sx + (RW+3)'(ROWS);
    else if (sx >= ROWS) sx = sx - (RW+3)'(ROWS);
    sy = $signed({3'b000, y}) + (CW+3)'(off.dy);
    if (sy < 0) sy = sy + (CW+3)'(COLS);
    else if (sy >= COLS) sy = sy - (CW+3)'(COLS);
    tz = sz[LW-1:0];
    tx = sx[RW-1:0];
    ty = sy[CW-1:0];
    gen_addr = AW'((int'(tz) * ROWS + int'(tx)) * COLS + int'(ty));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      caddr <= '0;
      cx    <= '0;
      cy    <= '0;
    end else if (cmd.clear_wr) begin
      caddr <= caddr + 1'b1;
      if (cy == CW'(COLS - 1)) begin
        cy <= '0;
        cx <= (cx == RW'(ROWS - 1)) ? '0 : cx + 1'b1;
      end else begin
        cy <= cy + 1'b1;
      end
    end
  end

  always_comb begin
    crow = 2'(cx);
    if (cx[0] ^ cy[0]) cval = (crow < 2'd2) ? 2'd3 : 2'd1;
    else cval = ((crow == 2'd1) || (crow == 2'd2)) ? 2'd2 : 2'd0;
  end

  always_comb begin
    mem_we    = cmd.clear_wr | cmd.wr_site | cmd.wr_link | cmd.wr_item;
    mem_waddr = cmd.clear_wr ? caddr : gen_addr;
    mem_wdata = wh;
    if (cmd.clear_wr) mem_wdata = cval;
    else if (cmd.wr_site) mem_wdata = hs[0] ^ 2'b10;
    else if (cmd.wr_link) mem_wdata = hs[13] ^ 2'b10;
  end

  dhsu_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (gen_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.read_issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= step;
    rd_par  <= tx[0] ^ ty[0];
    rd_site <= (tz == z) && (tx == x) && (ty == y);
    if (rd_pend) begin
      hs[rd_slot] <= mem_rdata;
      ps[rd_slot] <= rd_par;
      ss[rd_slot] <= rd_site;
    end
  end

  always_comb begin
    for (int i = 0; i < 13; i++) begin
      va[i] = ss[i] ? (hs[i] ^ 2'b10) : hs[i];
    end
    bs = plaq_ok(hs[0], hs[2], hs[1], hs[3], hs[4], ps[0]);
    ba = plaq_ok(hs[1], hs[0], hs[5], hs[9], hs[10], ps[1]);
    bb = plaq_ok(hs[2], hs[6], hs[0], hs[11], hs[12], ps[2]);
    bc = plaq_ok(hs[3], hs[11], hs[9], hs[7], hs[0], ps[3]);
    bd = plaq_ok(hs[4], hs[12], hs[10], hs[0], hs[8], ps[4]);
    aa = plaq_ok(va[1], va[0], va[5], va[9], va[10], ps[1]);
    ab = plaq_ok(va[2], va[6], va[0], va[11], va[12], ps[2]);
    ac = plaq_ok(va[3], va[11], va[9], va[7], va[0], ps[3]);
    ad = plaq_ok(va[4], va[12], va[10], va[0], va[8], ps[4]);
    kb = 3'(ba) + 3'(bb) + 3'(bc) + 3'(bd);
    ka = 3'(aa) + 3'(ab) + 3'(ac) + 3'(ad);
    match = (hs[1] == hs[14]) && (hs[2] == hs[15]) && (hs[3] == hs[16]) && (hs[4] == hs[17]);
    c1 = (hs[0] == hs[18]);
    c2 = (hs[13] == hs[19]);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      k_reg      <= $signed({1'b0, ka}) - $signed({1'b0, kb});
      c_reg      <= (c1 && c2) ? 3'sd2 : ((c1 || c2) ? 3'sd0 : -3'sd2);
      parity_reg <= (z[0] == ps[0]);
      flip_reg   <= bs && match;
    end
    if (cmd.mult) begin
      p1 <= k_reg * energy_step;
      p2 <= c_reg * $signed({1'b0, link_weight});
    end
  end

  assign bound = 21'(p1) + 21'(p2);

  always_ff @(posedge clk) begin
    if (cmd.set_outcome) outcome_q <= cmd.outcome;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_outcome <= outcome_q;
      if (act == ACT_WRITE) out_height <= wh;
      else if (outcome_q == OUT_FLIPPED) out_height <= hs[0] ^ 2'b10;
      else out_height <= hs[0];
    end
  end

  always_comb begin
    sts.reduce_done = ({1'b0, zi} < ZLIM) && ({1'b0, xi} < XLIM) && ({1'b0, yi} < YLIM);
    sts.is_attempt  = (act == ACT_FLIP);
    sts.is_write    = (act == ACT_WRITE);
    sts.read_last   = sts.is_attempt ? (step == SLOT_LAST) : (step == '0);
    sts.clear_last  = (caddr == AW'(DEPTH - 1));
    sts.parity_ok   = parity_reg;
    sts.flippable   = flip_reg;
    sts.accept      = $signed({5'b00000, nlu}) > bound;
    sts.out_free    = !out_valid || out_ready;
  end
endmodule

// ----- design/dhsu_ctrl.sv -----
module dhsu_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  dhsu_pkg::dhsu_status_t sts,
  output dhsu_pkg::dhsu_cmd_t    cmd
);
  import dhsu_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_REDUCE  = 12'b000000000100,
    S_READ    = 12'b000000001000,
    S_DRAIN   = 12'b000000010000,
    S_EVAL    = 12'b000000100000,
    S_MULT    = 12'b000001000000,
    S_DECIDE  = 12'b000010000000,
    S_FLIP_Z  = 12'b000100000000,
    S_FLIP_Z1 = 12'b001000000000,
    S_WRITE   = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts.reduce_done) state_next = sts.is_write ? S_WRITE : S_READ;
        else cmd.reduce = 1'b1;
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
        if (sts.read_last) state_next = S_DRAIN;
        else cmd.step_inc = 1'b1;
      end
      S_DRAIN: begin
        if (sts.is_attempt) begin
          state_next = S_EVAL;
        end else begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = OUT_DONE;
          state_next      = S_RESP;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult = 1'b1;
        if (!sts.parity_ok) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = OUT_WRONG_SUB;
          state_next      = S_RESP;
        end else if (!sts.flippable) begin
          cmd.set_outcome = 1'b1;
          cmd.outcome     = OUT_NOT_FLIP;
          state_next      = S_RESP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_outcome = 1'b1;
        if (sts.accept) begin
          cmd.outcome = OUT_FLIPPED;
          state_next  = S_FLIP_Z;
        end else begin
          cmd.outcome = OUT_REJECT;
          state_next  = S_RESP;
        end
      end
      S_FLIP_Z: begin
        cmd.wr_site = 1'b1;
        state_next  = S_FLIP_Z1;
      end
      S_FLIP_Z1: begin
        cmd.wr_link = 1'b1;
        state_next  = S_RESP;
      end
      S_WRITE: begin
        cmd.wr_item     = 1'b1;
        cmd.set_outcome = 1'b1;
        cmd.outcome     = OUT_DONE;
        state_next      = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

// ----- design/dimer_height_site_update_core.sv -----
// Flip attempt: reduce, read all 20 slots, evaluate, multiply, decide, write back the site and
// the upper layer site; a wrong sublattice or a site that cannot flip ends after multiply, a
// reject after decide. Reduce wraps out-of-range coordinates by subtraction. Read: reduce, one
// lattice read; write: reduce, one write. One item at a time: the next beat is taken in the
// cycle after the result is loaded into the output register, where it waits. Reset (synchronous,
// active high) loads the columnar pattern into all LAYERS*ROWS*COLS sites (640 by default).
`include "dimer_height_site_update_core_macros.svh"

module dimer_height_site_update_core #(
  parameter int ROWS   = dhsu_pkg::DHSU_ROWS,
  parameter int COLS   = dhsu_pkg::DHSU_COLS,
  parameter int LAYERS = dhsu_pkg::DHSU_LAYERS
) (
  input  logic          clk,
  input  logic          rst,
  dhsu_item_if.sink     item,
  dhsu_result_if.source result,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import dhsu_pkg::*;

  dhsu_cmd_t    cmd;
  dhsu_status_t sts;
  item_t        item_data;
  logic         ready_int;

  assign item_data.action          = item.action;
  assign item_data.layer_index     = item.layer_index;
  assign item_data.row             = item.row;
  assign item_data.col             = item.col;
  assign item_data.neg_log_uniform = item.neg_log_uniform;
  assign item_data.write_height    = item.write_height;
  assign item.ready                = ready_int;

  dhsu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (ready_int),
    .sts        (sts),
    .cmd        (cmd)
  );

  dhsu_datapath #(.ROWS(ROWS), .COLS(COLS), .LAYERS(LAYERS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .item_data   (item_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .out_outcome (result.outcome),
    .out_height  (result.read_height)
  );

  `DHSU_ASSERT_IMP(a_no_accept_in_clear, clk, rst, cmd.clear_wr, !ready_int, "beat taken during clear")
  `DHSU_ASSERT_IMP(a_out_not_overwritten, clk, rst, cmd.out_load, sts.out_free, "pending result overwritten")
  `DHSU_ASSERT_NXT(a_flip_pair, clk, rst, cmd.wr_site, cmd.wr_link, "site flip without upper layer flip")
endmodule

// ----- test/dhsu_checker.sv -----
module dhsu_checker (
  input  logic        clk,
  input  logic        rst,
  dhsu_item_if        item,
  dhsu_result_if      result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import dhsu_pkg::*;

  localparam int R = DHSU_ROWS;
  localparam int C = DHSU_COLS;
  localparam int L = DHSU_LAYERS;

  typedef struct packed {
    logic [2:0] outcome;
    logic [1:0] height;
  } site_result_t;

  height_t           heights[L][R][C];
  logic signed [15:0] energy_step;
  logic [15:0]        link_weight;
  site_result_t       expected_q[$];

  assign pending = expected_q.size();

  function automatic height_t h_at(int z, int x, int y);
    return heights[(z + L) % L][(x + R) % R][(y + C) % C];
  endfunction

  function automatic bit plaquette_flips(int z, int x, int y);
    height_t hc, want;
    x = (x + R) % R;
    y = (y + C) % C;
    hc = h_at(z, x, y);
    want = ((x + y + 1) & 1) ? 2'd3 : 2'd1;
    if (height_t'(hc - h_at(z, x - 1, y)) == 2'd1 && height_t'(h_at(z, x + 1, y) - hc) == 2'd1)
      return 1;
    return height_t'(h_at(z, x, y + 1) - hc) == want && height_t'(h_at(z, x, y - 1) - hc) == want;
  endfunction

  function automatic int ring_count(int z, int x, int y);
    return plaquette_flips(z, x + 1, y) + plaquette_flips(z, x - 1, y) +
           plaquette_flips(z, x, y + 1) + plaquette_flips(z, x, y - 1);
  endfunction

  function automatic bit ring_matches(int z, int x, int y);
    return h_at(z, x + 1, y) == h_at(z + 1, x + 1, y) && h_at(z, x - 1, y) == h_at(z + 1, x - 1, y)
        && h_at(z, x, y + 1) == h_at(z + 1, x, y + 1) && h_at(z, x, y - 1) == h_at(z + 1, x, y - 1);
  endfunction

  function automatic outcome_t try_flip(int z, int x, int y, int nlu);
    int k, c, bound;
    if ((z & 1) != ((x + y) & 1)) return OUT_WRONG_SUB;
    if (!plaquette_flips(z, x, y) || !ring_matches(z, x, y)) return OUT_NOT_FLIP;
    k = -ring_count(z, x, y);
    heights[z][x][y] += 2'd2;
    k += ring_count(z, x, y);
    heights[z][x][y] += 2'd2;
    c = (h_at(z, x, y) == h_at(z - 1, x, y)) ? 1 : -1;
    c += (h_at(z + 1, x, y) == h_at(z + 2, x, y)) ? 1 : -1;
    bound = k * int'(energy_step) + c * int'(link_weight);
    if (!(nlu > bound)) return OUT_REJECT;
    heights[z][x][y] += 2'd2;
    heights[(z + 1) % L][x][y] += 2'd2;
    return OUT_FLIPPED;
  endfunction

  task automatic report(string what, logic [2:0] got_o, logic [1:0] got_h, site_result_t exp_r);
    $display("mismatch %s: outcome %0d height %0d, expected outcome %0d height %0d",
             what, got_o, got_h, exp_r.outcome, exp_r.height);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int z, x, y;
    site_result_t r, e;
    if (rst) begin
      for (int a = 0; a < L; a++)
        for (int b = 0; b < R; b++)
          for (int d = 0; d < C; d++)
            if ((b + d) & 1) heights[a][b][d] = ((b & 3) < 2) ? 2'd3 : 2'd1;
            else heights[a][b][d] = ((b & 3) == 1 || (b & 3) == 2) ? 2'd2 : 2'd0;
      energy_step = 16'sd46;
      link_weight = 16'd3069;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENERGY_STEP) energy_step = cfg_data;
        else link_weight = cfg_data;
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", result.outcome, result.read_height, '0);
        end else begin
          e = expected_q.pop_front();
          if (result.outcome !== e.outcome) report("outcome", result.outcome, result.read_height, e);
          else if (result.read_height !== e.height)
            report("height", result.outcome, result.read_height, e);
        end
      end
      if (item.valid && item.ready) begin
        z = int'(item.layer_index) % L;
        x = int'(item.row) % R;
        y = int'(item.col) % C;
        r.outcome = OUT_DONE;
        if (item.action == ACT_FLIP) r.outcome = try_flip(z, x, y, int'(item.neg_log_uniform));
        else if (item.action == ACT_WRITE) heights[z][x][y] = item.write_height;
        r.height = heights[z][x][y];
        expected_q.push_back(r);
      end
    end
  end
endmodule

// ----- test/tb.sv -----
module tb;
  import dhsu_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          no_idle;

  dhsu_item_if   item ();
  dhsu_result_if result ();

  dimer_height_site_update_core dut (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dhsu_checker chk (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    result.ready <= no_idle || ($urandom_range(99) >= 33);
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high after the accepting edge; drop it while idling or in drain
  task automatic send(logic [1:0] act, logic [5:0] z, logic [1:0] x, logic [1:0] y,
                      logic [15:0] nlu, logic [1:0] wh);
    while (!no_idle && $urandom_range(99) < 33) begin
      item.valid <= 0;
      @(posedge clk);
    end
    item.valid <= 1;
    item.action <= act;
    item.layer_index <= z;
    item.row <= x;
    item.col <= y;
    item.neg_log_uniform <= nlu;
    item.write_height <= wh;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic drain();
    item.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] es, logic [15:0] lw);
    cfg_we <= 1;
    cfg_index <= CFG_ENERGY_STEP;
    cfg_data <= es;
    @(posedge clk);
    cfg_index <= CFG_LINK_WEIGHT;
    cfg_data <= lw;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int n);
    logic [5:0] z;
    logic [1:0] x, y;
    int pick;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 2) && (i < n / 2 + 40);
      pick = $urandom_range(99);
      z = (pick < 10) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
      x = 2'($urandom);
      y = 2'($urandom);
      if (pick < 70) begin
        if ((z & 1) != ((x + y) & 1) && pick > 5) y = y ^ 2'd1;
        send(ACT_FLIP, z, x, y, 16'($urandom), 2'($urandom));
      end else if (pick < 85) begin
        send(ACT_READ, z, x, y, 16'($urandom), 2'($urandom));
      end else if (pick < 95) begin
        send(ACT_WRITE, z, x, y, 16'($urandom), 2'($urandom));
      end else begin
        send(ACT_SPARE, z, x, y, 16'($urandom), 2'($urandom));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    cycle_count = 0;
    no_idle = 0;
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    item.valid <= 0;
    item.action <= 0;
    item.layer_index <= 0;
    item.row <= 0;
    item.col <= 0;
    item.neg_log_uniform <= 0;
    item.write_height <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    send(ACT_READ, 6'd0, 2'd0, 2'd0, 16'h0000, 2'd0);
    send(ACT_FLIP, 6'd0, 2'd0, 2'd1, 16'hffff, 2'd3);
    send(ACT_FLIP, 6'd0, 2'd0, 2'd0, 16'hffff, 2'd0);
    send(ACT_FLIP, 6'd1, 2'd0, 2'd1, 16'hffff, 2'd0);
    send(ACT_FLIP, 6'd0, 2'd1, 2'd1, 16'h0000, 2'd0);
    send(ACT_FLIP, 6'd39, 2'd3, 2'd0, 16'hffff, 2'd0);
    send(ACT_FLIP, 6'd63, 2'd3, 2'd3, 16'h8000, 2'd0);
    send(ACT_WRITE, 6'd39, 2'd3, 2'd3, 16'hffff, 2'd3);
    send(ACT_WRITE, 6'd45, 2'd2, 2'd1, 16'h0000, 2'd1);
    send(ACT_READ, 6'd5, 2'd2, 2'd1, 16'h0000, 2'd0);
    send(ACT_SPARE, 6'd63, 2'd3, 2'd3, 16'hffff, 2'd3);
    send(ACT_FLIP, 6'd2, 2'd2, 2'd2, 16'h7fff, 2'd0);
    send(ACT_FLIP, 6'd2, 2'd2, 2'd2, 16'hffff, 2'd0);
    drain();

    set_regs(16'h8000, 16'h0000);
    random_phase(250);
    drain();
    set_regs(16'h7fff, 16'hffff);
    random_phase(250);
    drain();
    set_regs(16'd46, 16'd3069);
    random_phase(250);
    drain();
    set_regs(16'($urandom), 16'($urandom_range(4000)));
    random_phase(250);
    drain();

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/dhsu_pkg.sv
design/dhsu_item_if.sv
design/dhsu_result_if.sv
design/dhsu_ram.sv
design/dhsu_datapath.sv
design/dhsu_ctrl.sv
design/dimer_height_site_update_core.sv
test/dhsu_checker.sv
test/tb.sv
